@@ rtl/sae_pkg.sv @@
// Package for the stack ALU engine: word types, operation and status codes.
// Used by sae_mdu and stack_alu_engine_top under rtl; depends on nothing.
`default_nettype none
package sae_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 64;

    typedef enum logic [4:0] {
        FN_PUSH = 5'd0,  FN_ADD = 5'd1,  FN_SUB = 5'd2,  FN_MUL = 5'd3,
        FN_MOD  = 5'd4,  FN_SHR = 5'd5,  FN_SHL = 5'd6,  FN_XOR = 5'd7,
        FN_OR   = 5'd8,  FN_AND = 5'd9,  FN_LT  = 5'd10, FN_GT  = 5'd11,
        FN_CMP  = 5'd12, FN_NOT = 5'd13, FN_INC = 5'd14, FN_DEC = 5'd15,
        FN_POP  = 5'd16, FN_PEEK = 5'd17
    } func_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_DIVZ = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READB, S_READA, S_EXEC, S_ITER, S_WRITE, S_REREAD, S_OUT
    } state_t;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [63:0] immediate;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] top_value;
        logic [8:0]         stack_count;
        logic [1:0]         status;
    } out_word_t;

    // Request to the multi-cycle unit and its answer.
    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [63:0] a;
        logic [63:0] b;
    } mdu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mdu_rsp_t;

endpackage
`default_nettype wire

@@ rtl/sae_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sae_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/sae_mdu.sv @@
// Iterative multiply and signed remainder unit, one bit per cycle.
// Depends on sae_pkg.
`default_nettype none
module sae_mdu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sae_pkg::mdu_req_t req,
    output sae_pkg::mdu_rsp_t      rsp
);
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        mod_reg, mod_next;
    logic        neg_reg, neg_next;
    logic [63:0] acc_reg, acc_next;     // product or partial remainder
    logic [63:0] opa_reg, opa_next;     // multiplicand or dividend shifting out
    logic [63:0] opb_reg, opb_next;     // multiplier or divisor magnitude
    logic [64:0] trial;
    logic [63:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        mod_next  = mod_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        rem_sh    = {acc_reg[62:0], opa_reg[63]};
        trial     = {1'b0, rem_sh} - {1'b0, opb_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            mod_next  = req.is_mod;
            neg_next  = req.a[63];
            acc_next  = '0;
            if (req.is_mod)
            begin
                opa_next = req.a[63] ? (64'd0 - req.a) : req.a;
                opb_next = req.b[63] ? (64'd0 - req.b) : req.b;
            end
            else
            begin
                opa_next = req.a;
                opb_next = req.b;
            end
        end
        else if (busy_reg)
        begin
            if (mod_reg)
            begin
                // Restoring division step on magnitudes.
                acc_next = trial[64] ? rem_sh : trial[63:0];
                opa_next = {opa_reg[62:0], 1'b0};
            end
            else
            begin
                // Shift-add multiply step, low 64 bits kept.
                acc_next = acc_reg + (opb_reg[0] ? opa_reg : 64'd0);
                opa_next = {opa_reg[62:0], 1'b0};
                opb_next = {1'b0, opb_reg[63:1]};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg <= mod_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
    end

    // Done pulses the cycle after the last step.
    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == 7'd63);
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (mod_reg && neg_reg) ? (64'd0 - acc_reg) : acc_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start) else $error("mdu restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg)) else $error("mdu done without work");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !done_reg || cnt_reg == 7'd64) else $error("mdu count off");
endmodule
`default_nettype wire

@@ rtl/stack_alu_engine_top.sv @@
// Top level of the stack ALU engine: control sequencer, stack RAM, ALU.
// Depends on sae_pkg, sae_ram and sae_mdu.
//
//  channel   direction  handshake       payload
//  in        input      in_valid/ready  sae_pkg::in_word_t  (func, immediate)
//  out       output     out_valid/ready sae_pkg::out_word_t (top, count, status)
//
// An item: reads of b and a from the one-port-read stack RAM, execute, write
// back and a re-read of the new top; mul, and mod with a nonzero divisor,
// also use the bit-serial unit. The output register frees the sequencer, so
// the next item is accepted while a result waits; a new result waits for it.
// Reset clears the count and control; stack contents are undefined until pushed.
`default_nettype none
module stack_alu_engine_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sae_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sae_pkg::out_word_t      out_data
);
    localparam int AW = sae_pkg::ADDR_W;
    localparam int CW = sae_pkg::COUNT_W;

    sae_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [4:0]        func_reg, func_next;
    logic [63:0]       imm_reg, imm_next;
    logic [63:0]       b_reg, b_next;
    logic [63:0]       res_reg, res_next;
    logic [63:0]       top_reg, top_next;     // popped or known top value
    logic [1:0]        st_reg, st_next;
    logic              ovalid_reg, ovalid_next;
    sae_pkg::out_word_t odata_reg, odata_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [63:0]       wdata, rdata;
    sae_pkg::mdu_req_t mreq;
    sae_pkg::mdu_rsp_t mrsp;

    logic              is_bin, is_un, need_mdu;
    logic [63:0]       a_val, alu_out;
    logic [5:0]        sh;
    logic              in_fire;

    sae_ram #(.WIDTH(64), .DEPTH(sae_pkg::STACK_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    sae_mdu u_mdu (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    assign in_fire = in_valid && in_ready;
    assign is_bin  = (func_reg >= sae_pkg::FN_ADD) && (func_reg <= sae_pkg::FN_CMP);
    assign is_un   = (func_reg >= sae_pkg::FN_NOT) && (func_reg <= sae_pkg::FN_DEC);
    assign a_val   = rdata;
    assign sh      = b_reg[5:0];
    assign need_mdu = (func_reg == sae_pkg::FN_MUL) ||
                      ((func_reg == sae_pkg::FN_MOD) && (b_reg != 64'd0));

    // Combinational ALU on a (RAM data) and b.
    always_comb
    begin
        unique case (func_reg)
            sae_pkg::FN_ADD: alu_out = a_val + b_reg;
            sae_pkg::FN_SHR: alu_out = 64'($signed(a_val) >>> sh);
            sae_pkg::FN_SHL: alu_out = a_val << sh;
            sae_pkg::FN_XOR: alu_out = a_val ^ b_reg;
            sae_pkg::FN_OR:  alu_out = a_val | b_reg;
            sae_pkg::FN_AND: alu_out = a_val & b_reg;
            sae_pkg::FN_LT:  alu_out = {63'd0, $signed(a_val) < $signed(b_reg)};
            sae_pkg::FN_GT:  alu_out = {63'd0, $signed(a_val) > $signed(b_reg)};
            sae_pkg::FN_NOT: alu_out = ~b_reg;
            sae_pkg::FN_INC: alu_out = b_reg + 64'd1;
            sae_pkg::FN_DEC: alu_out = b_reg - 64'd1;
            default:         alu_out = a_val - b_reg;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sae_pkg::S_IDLE:   if (in_fire) state_next = sae_pkg::S_READB;
            sae_pkg::S_READB:
            begin
                if (func_reg == sae_pkg::FN_PUSH)
                    state_next = (count_reg >= CW'(sae_pkg::STACK_DEPTH)) ?
                                 sae_pkg::S_REREAD : sae_pkg::S_WRITE;
                else if (is_bin)
                    state_next = (count_reg < CW'(2)) ? sae_pkg::S_REREAD
                                                      : sae_pkg::S_READA;
                else if (count_reg == '0 || func_reg > sae_pkg::FN_PEEK)
                    state_next = sae_pkg::S_REREAD;
                else
                    state_next = sae_pkg::S_READA;
            end
            sae_pkg::S_READA:  state_next = sae_pkg::S_EXEC;
            sae_pkg::S_EXEC:
            begin
                if (is_bin && need_mdu)
                    state_next = sae_pkg::S_ITER;
                else if ((is_bin && func_reg == sae_pkg::FN_MOD) ||
                         func_reg == sae_pkg::FN_PEEK)
                    state_next = sae_pkg::S_REREAD;
                else
                    state_next = sae_pkg::S_WRITE;
            end
            sae_pkg::S_ITER:   if (mrsp.done) state_next = sae_pkg::S_WRITE;
            sae_pkg::S_WRITE:  state_next = sae_pkg::S_REREAD;
            sae_pkg::S_REREAD: state_next = sae_pkg::S_OUT;
            sae_pkg::S_OUT:
                if (!ovalid_reg || out_ready) state_next = sae_pkg::S_IDLE;
            default:           state_next = sae_pkg::S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        count_next  = count_reg;
        func_next   = func_reg;
        imm_next    = imm_reg;
        b_next      = b_reg;
        res_next    = res_reg;
        top_next    = top_reg;
        st_next     = st_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        we          = 1'b0;
        waddr       = AW'(count_reg - CW'(1));
        wdata       = res_reg;
        raddr       = AW'(count_reg - CW'(1));
        mreq        = '0;
        in_ready    = (state_reg == sae_pkg::S_IDLE);
        if (out_valid && out_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            sae_pkg::S_IDLE:
            begin
                func_next = in_data.func;
                imm_next  = in_data.immediate;
                st_next   = sae_pkg::ST_OK;
            end
            sae_pkg::S_READB:
            begin
                // Top read issued here; second entry read follows.
                raddr = AW'(count_reg - CW'(1));
                if (func_reg == sae_pkg::FN_PUSH)
                begin
                    if (count_reg >= CW'(sae_pkg::STACK_DEPTH))
                        st_next = sae_pkg::ST_FULL;
                    res_next = imm_reg;
                end
                else if ((is_bin && count_reg < CW'(2)) ||
                         ((is_un || func_reg == sae_pkg::FN_POP ||
                           func_reg == sae_pkg::FN_PEEK) && count_reg == '0))
                    st_next = sae_pkg::ST_EMPTY;
            end
            sae_pkg::S_READA:
            begin
                b_next = rdata;
                raddr  = AW'(count_reg - CW'(2));
            end
            sae_pkg::S_EXEC:
            begin
                res_next = alu_out;
                top_next = b_reg;
                if (is_bin && func_reg == sae_pkg::FN_MOD && b_reg == 64'd0)
                    st_next = sae_pkg::ST_DIVZ;
                mreq.start  = is_bin && need_mdu;
                mreq.is_mod = (func_reg == sae_pkg::FN_MOD);
                mreq.a      = a_val;
                mreq.b      = b_reg;
            end
            sae_pkg::S_ITER:
                if (mrsp.done) res_next = mrsp.result;
            sae_pkg::S_WRITE:
            begin
                we = (func_reg != sae_pkg::FN_POP);
                if (func_reg == sae_pkg::FN_PUSH)
                begin
                    waddr      = AW'(count_reg);
                    count_next = count_reg + CW'(1);
                end
                else if (is_bin)
                begin
                    waddr      = AW'(count_reg - CW'(2));
                    count_next = count_reg - CW'(1);
                end
                else if (func_reg == sae_pkg::FN_POP)
                    count_next = count_reg - CW'(1);
            end
            sae_pkg::S_REREAD:
                raddr = AW'(count_reg - CW'(1));
            sae_pkg::S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next           = 1'b1;
                    odata_next.stack_count = 9'(count_reg);
                    odata_next.status      = st_reg;
                    if (func_reg == sae_pkg::FN_POP && st_reg == sae_pkg::ST_OK)
                        odata_next.top_value = top_reg;
                    else if (count_reg == '0)
                        odata_next.top_value = '0;
                    else
                        odata_next.top_value = rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sae_pkg::S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        imm_reg   <= imm_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        top_reg   <= top_next;
        st_reg    <= st_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(sae_pkg::STACK_DEPTH)) else $error("count overflow");
    a_count_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sae_pkg::S_WRITE) |=> $stable(count_reg))
        else $error("count changed outside write");
    a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sae_pkg::S_WRITE) |-> st_reg == sae_pkg::ST_OK)
        else $error("write with error status");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == sae_pkg::S_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire

@@ verif/sae_checker.sv @@
// Checker for the stack ALU engine: watches both channels, predicts each result word.
// Depends on sae_pkg for the word types and the operation and status codes.
module sae_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire sae_pkg::in_word_t  in_data,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire sae_pkg::out_word_t out_data,
    output int                      errors,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sae_pkg::*;

    logic [63:0] op_stack [STACK_DEPTH];
    int          depth_now;
    out_word_t   awaited_words [$];

    // Signed remainder with the sign of the dividend.
    function automatic logic [63:0] rem_signed(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        r = ma % mb;
        return a[63] ? -r : r;
    endfunction

    // Apply one operation to the shadow stack and return the result word.
    function automatic out_word_t execute_op(in_word_t w);
        out_word_t   o;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic        have_top;
        logic        commit;
        o = '0;
        have_top = 1'b0;
        o.status = ST_OK;
        if (w.func == FN_PUSH) begin
            if (depth_now >= STACK_DEPTH) o.status = ST_FULL;
            else
            begin
                op_stack[depth_now] = w.immediate;
                depth_now++;
            end
        end
        else if (w.func >= FN_ADD && w.func <= FN_CMP) begin
            if (depth_now < 2) o.status = ST_EMPTY;
            else
            begin
                b = op_stack[depth_now-1];
                a = op_stack[depth_now-2];
                r = '0;
                commit = 1'b1;
                case (func_t'(w.func))
                    FN_ADD: r = a + b;
                    FN_SUB: r = a - b;
                    FN_MUL: r = a * b;
                    FN_MOD:
                    begin
                        if (b == 0) begin
                            o.status = ST_DIVZ;
                            commit = 1'b0;
                        end
                        else r = rem_signed(a, b);
                    end
                    FN_SHR: r = $signed(a) >>> b[5:0];
                    FN_SHL: r = a << b[5:0];
                    FN_XOR: r = a ^ b;
                    FN_OR:  r = a | b;
                    FN_AND: r = a & b;
                    FN_LT:  r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                    FN_GT:  r = ($signed(a) > $signed(b)) ? 64'd1 : 64'd0;
                    default: r = a - b;
                endcase
                if (commit) begin
                    depth_now--;
                    op_stack[depth_now-1] = r;
                end
            end
        end
        else if (w.func >= FN_NOT && w.func <= FN_DEC) begin
            if (depth_now < 1) o.status = ST_EMPTY;
            else if (w.func == FN_NOT) op_stack[depth_now-1] = ~op_stack[depth_now-1];
            else if (w.func == FN_INC) op_stack[depth_now-1] = op_stack[depth_now-1] + 1;
            else op_stack[depth_now-1] = op_stack[depth_now-1] - 1;
        end
        else if (w.func == FN_POP) begin
            if (depth_now < 1) o.status = ST_EMPTY;
            else
            begin
                o.top_value = op_stack[depth_now-1];
                depth_now--;
                have_top = 1'b1;
            end
        end
        else if (w.func == FN_PEEK) begin
            if (depth_now < 1) o.status = ST_EMPTY;
        end
        if (!have_top) o.top_value = (depth_now == 0) ? '0 : op_stack[depth_now-1];
        o.stack_count = depth_now[8:0];
        return o;
    endfunction

    // Predict on every accepted input word, compare on every accepted result word.
    always @(posedge clk or negedge rst_n) begin
        out_word_t want;
        if (!rst_n) begin
            depth_now = 0;
            errors = 0;
            awaited_words.delete();
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready) awaited_words.push_back(execute_op(in_data));
            if (out_valid && out_ready) begin
                if (awaited_words.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (out_data.top_value !== want.top_value) begin
                        $error("top_value expected %h actual %h",
                               want.top_value, out_data.top_value);
                        errors++;
                    end
                    if (out_data.stack_count !== want.stack_count) begin
                        $error("stack_count expected %0d actual %0d",
                               want.stack_count, out_data.stack_count);
                        errors++;
                    end
                    if (out_data.status !== want.status) begin
                        $error("status expected %0d actual %0d",
                               want.status, out_data.status);
                        errors++;
                    end
                end
            end
            pending = awaited_words.size();
        end
    end
endmodule

@@ verif/tb_stack_alu_engine_top.sv @@
// Testbench top for the stack ALU engine: clock, reset, stimulus, verdict.
// Depends on sae_pkg, stack_alu_engine_top and sae_checker.
module tb_stack_alu_engine_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sae_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;
    int        errors;
    int        pending;
    int        idle_cycles = 0;
    int        words_sent = 0;
    int        results_seen = 0;
    int        model_depth = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stack_alu_engine_top DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    sae_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data), .errors(errors), .pending(pending)
    );

    // Random operand with a bias toward edge values.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'hffff_ffff_ffff_ffff;
            3: return 64'd0;
            4: return 64'($urandom_range(0, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Send one word after a random gap; tracks stack depth for stimulus shaping.
    // Valid drops only when a gap follows, so a back-to-back word keeps it high.
    task automatic send_word(logic [4:0] f, logic [63:0] imm);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{func: f, immediate: imm};
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (f == FN_PUSH && model_depth < STACK_DEPTH) model_depth++;
        else if (f >= FN_ADD && f <= FN_CMP && model_depth >= 2) model_depth--;
        else if (f == FN_POP && model_depth >= 1) model_depth--;
    endtask

    // Receiver: random stall per word, with some stall-free stretches.
    always @(posedge clk) begin
        int stall;
        if (rst_n && out_valid && out_ready) results_seen++;
        if (!rst_n) out_ready <= 1'b0;
        else if (out_ready && out_valid) out_ready <= 1'b0;
        else if (!out_ready) begin
            stall = (results_seen % 200 < 50) ? 0 : $urandom_range(0, 15);
            repeat (stall) @(posedge clk);
            out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [4:0] f;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ops on an empty stack, then edge values for mod, shifts, lt and pop.
        for (int k = FN_ADD; k <= FN_PEEK; k += 4) send_word(k[4:0], '1);
        send_word(FN_PUSH, 64'h8000_0000_0000_0000);
        send_word(FN_PUSH, 64'hffff_ffff_ffff_ffff);
        send_word(FN_MOD, 64'd0);
        send_word(FN_PUSH, 64'd0);
        send_word(FN_MOD, 64'd0);
        send_word(FN_PUSH, 64'd70);
        send_word(FN_SHR, 64'd0);
        send_word(FN_PUSH, 64'd65);
        send_word(FN_SHL, 64'd0);
        send_word(FN_PUSH, 64'h7fff_ffff_ffff_ffff);
        send_word(FN_LT, 64'd0);
        send_word(FN_PEEK, 64'd0);
        send_word(5'd31, 64'd0);
        send_word(FN_POP, 64'd0);
        send_word(FN_POP, 64'd0);

        // Fill to full and push once more, then run each binary operation once.
        for (int k = 0; k <= STACK_DEPTH; k++) send_word(FN_PUSH, pick_operand());
        for (int k = FN_ADD; k <= FN_CMP; k++) send_word(k[4:0], 64'd0);

        // Random: mostly valid operations, with underflow and unknown codes now and then.
        for (int k = 0; k < 1150; k++) begin
            case ($urandom_range(0, 19))
                0: f = 5'($urandom_range(18, 31));
                1, 2, 3, 4, 5: f = FN_PUSH;
                default: f = 5'($urandom_range(1, 17));
            endcase
            if (model_depth < 3 && $urandom_range(0, 3) != 0) f = FN_PUSH;
            if (model_depth > 20 && f == FN_PUSH && $urandom_range(0, 1) == 0) f = FN_ADD;
            send_word(f, pick_operand());
        end
        while (model_depth > 0) send_word(FN_POP, pick_operand());
        send_word(FN_PEEK, '1);
        in_valid <= 1'b0;

        // Drain the remaining results, then let the pipeline settle.
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Sent %0d operation words covering all codes, full and empty stack.",
                 words_sent);
        if (errors == 0 && pending == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

@@ files.f @@
rtl/sae_pkg.sv
rtl/sae_ram.sv
rtl/sae_mdu.sv
rtl/stack_alu_engine_top.sv
verif/sae_checker.sv
verif/tb_stack_alu_engine_top.sv
